// File: src/segmented_group_aggregator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segmented group aggregator
// Shared property templates; each use sits on a line of its own in the RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_GROUP_AGGREGATOR_ASSERT_SVH
`define SEGMENTED_GROUP_AGGREGATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define SGA_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset
`define SGA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/sga_pkg.sv
// ----------------------------------------------------------------------------
// sga_pkg
// Widths, limits and the closed-group record shared by the aggregator modules.
// ----------------------------------------------------------------------------
package sga_pkg;

   localparam int LABEL_BITS = 32;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 16;
   localparam int SUM_BITS   = VALUE_BITS + COUNT_BITS;

   // Queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Mean divider: one quotient bit per cycle
   localparam int DIV_STEPS    = SUM_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0]   SUM_MAX   = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0]   SUM_MIN   = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic [COUNT_BITS-1:0]        COUNT_MAX = {COUNT_BITS{1'b1}};

   // Quotient magnitude limits for clamping the mean
   localparam logic [SUM_BITS-1:0] MEAN_POS_LIMIT =
      {{(SUM_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
   localparam logic [SUM_BITS-1:0] MEAN_NEG_LIMIT =
      {{(SUM_BITS-VALUE_BITS){1'b0}}, 1'b1, {(VALUE_BITS-1){1'b0}}};

   // Aggregates of one closed group, as queued from front to back
   typedef struct packed {
      logic signed [SUM_BITS-1:0]   sum;
      logic signed [VALUE_BITS-1:0] min;
      logic signed [VALUE_BITS-1:0] max;
      logic signed [VALUE_BITS-1:0] first;
      logic signed [VALUE_BITS-1:0] last;
      logic [COUNT_BITS-1:0]        count;
      logic                         final_flag;
   } rec_type;

endpackage

// File: src/sga_front.sv
// ----------------------------------------------------------------------------
// sga_front
// Accepts requests, tracks the open run of equal labels and queues a record
// for every closed group (label change or end of stream).
// ----------------------------------------------------------------------------
`include "segmented_group_aggregator_assert.svh"

module sga_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [sga_pkg::LABEL_BITS-1:0]         req_group_label,
   input  logic signed [sga_pkg::VALUE_BITS-1:0]  req_sample_value,
   input  logic                                   req_end_of_stream,
   output logic                                   q_push,
   output sga_pkg::rec_type                       q_rec,
   input  logic                                   q_full
);

   logic                                  open_ff, open_in;
   logic                                  pending_ff, pending_in;
   logic [sga_pkg::LABEL_BITS-1:0]        label_ff, label_in;
   logic signed [sga_pkg::SUM_BITS-1:0]   sum_ff, sum_in;
   logic signed [sga_pkg::VALUE_BITS-1:0] min_ff, min_in;
   logic signed [sga_pkg::VALUE_BITS-1:0] max_ff, max_in;
   logic signed [sga_pkg::VALUE_BITS-1:0] first_ff, first_in;
   logic signed [sga_pkg::VALUE_BITS-1:0] last_ff, last_in;
   logic [sga_pkg::COUNT_BITS-1:0]        count_ff, count_in;

   logic                                  accept;
   logic                                  close_group;
   logic                                  flush;
   logic                                  fresh;
   logic signed [sga_pkg::SUM_BITS-1:0]   base_sum;
   logic signed [sga_pkg::VALUE_BITS-1:0] base_min;
   logic signed [sga_pkg::VALUE_BITS-1:0] base_max;
   logic [sga_pkg::COUNT_BITS-1:0]        base_count;
   logic [sga_pkg::SUM_BITS:0]            sum_wide;

   // Hold off requests while the queue is full or the end-of-stream record waits for queue room
   assign req_full    = q_full | pending_ff;
   assign accept      = req_push & ~req_full;
   assign close_group = accept & open_ff & (req_group_label != label_ff);
   assign flush       = pending_ff & ~q_full;
   assign fresh       = ~open_ff | close_group;

   // Queue the open group's aggregates on a label change or a flush
   assign q_push           = close_group | flush;
   assign q_rec.sum        = sum_ff;
   assign q_rec.min        = min_ff;
   assign q_rec.max        = max_ff;
   assign q_rec.first      = first_ff;
   assign q_rec.last       = last_ff;
   assign q_rec.count      = count_ff;
   assign q_rec.final_flag = pending_ff;

   // Start from empty aggregates when the item opens a new group
   assign base_sum   = fresh ? '0 : sum_ff;
   assign base_min   = fresh ? sga_pkg::VALUE_MAX : min_ff;
   assign base_max   = fresh ? sga_pkg::VALUE_MIN : max_ff;
   assign base_count = fresh ? '0 : count_ff;

   // Add one sign bit of headroom to detect sum overflow
   assign sum_wide = {base_sum[sga_pkg::SUM_BITS-1], base_sum}
                   + {{(sga_pkg::SUM_BITS+1-sga_pkg::VALUE_BITS)
                        {req_sample_value[sga_pkg::VALUE_BITS-1]}}, req_sample_value};

   // Update the run
   always_comb begin
      open_in    = open_ff;
      pending_in = pending_ff;
      label_in   = label_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      if (flush) begin
         open_in    = 1'b0;
         pending_in = 1'b0;
      end else if (accept) begin
         open_in    = 1'b1;
         pending_in = req_end_of_stream;
         label_in   = req_group_label;
         if (sum_wide[sga_pkg::SUM_BITS] != sum_wide[sga_pkg::SUM_BITS-1]) begin
            sum_in = sum_wide[sga_pkg::SUM_BITS] ? sga_pkg::SUM_MIN : sga_pkg::SUM_MAX;
         end else begin
            sum_in = sum_wide[sga_pkg::SUM_BITS-1:0];
         end
         min_in   = (req_sample_value < base_min) ? req_sample_value : base_min;
         max_in   = (req_sample_value > base_max) ? req_sample_value : base_max;
         first_in = fresh ? req_sample_value : first_ff;
         last_in  = req_sample_value;
         count_in = (base_count == sga_pkg::COUNT_MAX) ? base_count
                                                       : base_count + 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         open_ff    <= open_in;
         pending_ff <= pending_in;
      end
   end

   // Aggregates; only read while a group is open
   always_ff @(posedge clock) begin
      label_ff <= label_in;
      sum_ff   <= sum_in;
      min_ff   <= min_in;
      max_ff   <= max_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      count_ff <= count_in;
   end

   `SGA_ASSERT_IMPLY(a_front_pending_open, pending_ff, open_ff, "flush pending without open group")
   `SGA_ASSERT_IMPLY(a_front_count_nonzero, open_ff, count_ff != '0, "open group with zero count")

endmodule

// File: src/sga_queue.sv
// ----------------------------------------------------------------------------
// sga_queue
// Short first-in first-out queue of closed-group records between the front
// and the back.
// ----------------------------------------------------------------------------
`include "segmented_group_aggregator_assert.svh"

module sga_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sga_pkg::rec_type push_rec,
   output logic             full,
   input  logic             pop,
   output sga_pkg::rec_type pop_rec,
   output logic             empty
);

   sga_pkg::rec_type                  entry_ff [sga_pkg::QUEUE_DEPTH];
   logic [sga_pkg::QUEUE_PTR_BITS:0]  wr_ptr_ff, wr_ptr_in;
   logic [sga_pkg::QUEUE_PTR_BITS:0]  rd_ptr_ff, rd_ptr_in;
   logic                              do_push;
   logic                              do_pop;

   // Pointers carry one wrap bit to tell full from empty
   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[sga_pkg::QUEUE_PTR_BITS] != rd_ptr_ff[sga_pkg::QUEUE_PTR_BITS])
                & (wr_ptr_ff[sga_pkg::QUEUE_PTR_BITS-1:0]
                   == rd_ptr_ff[sga_pkg::QUEUE_PTR_BITS-1:0]);

   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign pop_rec   = entry_ff[rd_ptr_ff[sga_pkg::QUEUE_PTR_BITS-1:0]];

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Store the pushed record
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff[sga_pkg::QUEUE_PTR_BITS-1:0]] <= push_rec;
      end
   end

   `SGA_ASSERT_IMPLY(a_queue_no_overflow, push, !full, "record pushed into a full queue")

endmodule

// File: src/sga_back.sv
// ----------------------------------------------------------------------------
// sga_back
// Takes closed-group records from the queue, divides sum by count one
// quotient bit per cycle, clamps the mean and holds the result for popping.
// ----------------------------------------------------------------------------
`include "segmented_group_aggregator_assert.svh"

module sga_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_empty,
   input  sga_pkg::rec_type                       q_rec,
   output logic                                   q_pop,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [sga_pkg::SUM_BITS-1:0]    rsp_group_sum,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_min,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_max,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_first,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_last,
   output logic [sga_pkg::COUNT_BITS-1:0]         rsp_group_count,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_mean,
   output logic                                   rsp_final_result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                            state_ff, state_in;
   logic [sga_pkg::DIV_CNT_BITS-1:0]      step_ff, step_in;
   sga_pkg::rec_type                      hold_ff, hold_in;
   logic                                  neg_ff, neg_in;
   logic [sga_pkg::SUM_BITS-1:0]          quo_ff, quo_in;
   logic [sga_pkg::COUNT_BITS-1:0]        rem_ff, rem_in;
   logic                                  out_valid_ff, out_valid_in;
   sga_pkg::rec_type                      out_rec_ff, out_rec_in;
   logic signed [sga_pkg::VALUE_BITS-1:0] out_mean_ff, out_mean_in;

   logic [sga_pkg::COUNT_BITS:0]          trial;
   logic [sga_pkg::COUNT_BITS:0]          divisor;
   logic                                  load_out;
   logic [sga_pkg::SUM_BITS-1:0]          neg_quo;
   logic signed [sga_pkg::VALUE_BITS-1:0] mean;

   assign q_pop    = (state_ff == ST_IDLE) & ~q_empty;
   assign load_out = (state_ff == ST_DONE) & (~out_valid_ff | rsp_pop);

   // Restoring division step on the magnitude of the sum
   assign trial   = {rem_ff, quo_ff[sga_pkg::SUM_BITS-1]};
   assign divisor = {1'b0, hold_ff.count};

   // Restore the sign and clamp the quotient to the value range
   assign neg_quo = ~quo_ff + 1'b1;
   always_comb begin
      if (neg_ff) begin
         mean = (quo_ff > sga_pkg::MEAN_NEG_LIMIT) ? sga_pkg::VALUE_MIN
                                                   : neg_quo[sga_pkg::VALUE_BITS-1:0];
      end else begin
         mean = (quo_ff > sga_pkg::MEAN_POS_LIMIT) ? sga_pkg::VALUE_MAX
                                                   : quo_ff[sga_pkg::VALUE_BITS-1:0];
      end
   end

   // Sequence: take a record, divide, hand over to the output register
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      hold_in  = hold_ff;
      neg_in   = neg_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               hold_in  = q_rec;
               neg_in   = q_rec.sum[sga_pkg::SUM_BITS-1];
               quo_in   = q_rec.sum[sga_pkg::SUM_BITS-1] ? ~q_rec.sum + 1'b1 : q_rec.sum;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (trial >= divisor) begin
               rem_in = sga_pkg::COUNT_BITS'(trial - divisor);
               quo_in = {quo_ff[sga_pkg::SUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[sga_pkg::COUNT_BITS-1:0];
               quo_in = {quo_ff[sga_pkg::SUM_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == sga_pkg::DIV_CNT_BITS'(sga_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register; drop the result once popped
   assign out_valid_in = load_out | (out_valid_ff & ~rsp_pop);
   assign out_rec_in   = load_out ? hold_ff : out_rec_ff;
   assign out_mean_in  = load_out ? mean : out_mean_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      hold_ff     <= hold_in;
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      out_rec_ff  <= out_rec_in;
      out_mean_ff <= out_mean_in;
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_group_sum    = out_rec_ff.sum;
   assign rsp_group_min    = out_rec_ff.min;
   assign rsp_group_max    = out_rec_ff.max;
   assign rsp_group_first  = out_rec_ff.first;
   assign rsp_group_last   = out_rec_ff.last;
   assign rsp_group_count  = out_rec_ff.count;
   assign rsp_group_mean   = out_mean_ff;
   assign rsp_final_result = out_rec_ff.final_flag;

   `SGA_ASSERT_IMPLY(a_back_divisor_nonzero, state_ff == ST_DIV, hold_ff.count != '0, "divide by zero count")
   `SGA_ASSERT_NEXT(a_back_result_kept, out_valid_ff && !rsp_pop, out_valid_ff, "unpopped result lost")

endmodule

// File: src/segmented_group_aggregator.sv
// ----------------------------------------------------------------------------
// segmented_group_aggregator
// Run-length group-by aggregation: sum, min, max, first, last, count and mean
// for every run of equal labels in a stream of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_push / req_full with a label, a sample and an
//   end-of-stream flag. A request whose label differs from the open run
//   closes that run; a request with end_of_stream set closes its own run
//   afterwards, so one request can produce two results.
//   Results leave on rsp_empty / rsp_pop; the oldest result is on the rsp_
//   ports while rsp_empty is low and is taken when rsp_pop is high.
// Throughput: the front takes one request per cycle while the four-entry
//   record queue has room; an end-of-stream request holds req_full high
//   until its final record is queued.
//   The back takes a new record only after the bit-serial divider that
//   forms the mean has finished the last one and moved it to the output register.
// Path: a closed group's record passes the record queue, the divider and
//   the output register on its way to the rsp_ ports.
// Reset: synchronous; clears the open run, the queue and the output register.
// Stall: a result waits in the output register while rsp_pop is low; the
//   divider and queue keep filling behind it, then req_full rises.
// ----------------------------------------------------------------------------
module segmented_group_aggregator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [sga_pkg::LABEL_BITS-1:0]         req_group_label,
   input  logic signed [sga_pkg::VALUE_BITS-1:0]  req_sample_value,
   input  logic                                   req_end_of_stream,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [sga_pkg::SUM_BITS-1:0]    rsp_group_sum,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_min,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_max,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_first,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_last,
   output logic [sga_pkg::COUNT_BITS-1:0]         rsp_group_count,
   output logic signed [sga_pkg::VALUE_BITS-1:0]  rsp_group_mean,
   output logic                                   rsp_final_result
);

   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;
   sga_pkg::rec_type push_rec;
   sga_pkg::rec_type pop_rec;

   // Front: track runs and queue closed groups
   sga_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_group_label   (req_group_label),
      .req_sample_value  (req_sample_value),
      .req_end_of_stream (req_end_of_stream),
      .q_push            (q_push),
      .q_rec             (push_rec),
      .q_full            (q_full)
   );

   // Queue of closed-group records
   sga_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .full     (q_full),
      .pop      (q_pop),
      .pop_rec  (pop_rec),
      .empty    (q_empty)
   );

   // Back: mean divider and output register
   sga_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_rec            (pop_rec),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_group_sum    (rsp_group_sum),
      .rsp_group_min    (rsp_group_min),
      .rsp_group_max    (rsp_group_max),
      .rsp_group_first  (rsp_group_first),
      .rsp_group_last   (rsp_group_last),
      .rsp_group_count  (rsp_group_count),
      .rsp_group_mean   (rsp_group_mean),
      .rsp_final_result (rsp_final_result)
   );

endmodule

// File: bench/tb_segmented_group_aggregator.sv
// ----------------------------------------------------------------------------
// tb_segmented_group_aggregator
// Self-checking bench for the run-length group-by aggregator. A short table of
// directed requests (edge labels and samples, one-sample streams, truncating
// negative mean) is followed by random runs of equal labels under several
// idle mixes. Every accepted request is folded into a local model of the open
// group; every popped result is compared field by field against the oldest
// pending group.
// ----------------------------------------------------------------------------
module tb_segmented_group_aggregator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LABEL_BITS = sga_pkg::LABEL_BITS;
   localparam int VALUE_BITS = sga_pkg::VALUE_BITS;
   localparam int COUNT_BITS = sga_pkg::COUNT_BITS;
   localparam int SUM_BITS   = sga_pkg::SUM_BITS;
   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = sga_pkg::VALUE_MAX;
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = sga_pkg::VALUE_MIN;
   localparam logic signed [SUM_BITS-1:0]   SUM_MAX   = sga_pkg::SUM_MAX;
   localparam logic signed [SUM_BITS-1:0]   SUM_MIN   = sga_pkg::SUM_MIN;
   localparam logic [COUNT_BITS-1:0]        COUNT_MAX = sga_pkg::COUNT_MAX;

   localparam int CYCLE_LIMIT      = 3_000_000;
   localparam int HOLD_CYCLES      = 600;
   localparam int DRAIN_CYCLES     = 200;
   localparam int RANDOM_PER_PHASE = 280;
   localparam int REPORT_LIMIT     = 10;
   localparam int NUM_PHASES       = 5;
   localparam int NUM_ROWS         = 13;
   localparam int SEND_IDLE [NUM_PHASES] = '{0, 70, 0, 21, 0};
   localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 70, 21, 0};

   // Aggregates of one closed group, as seen on the rsp_ ports
   typedef struct packed {
      logic signed [SUM_BITS-1:0]   sum;
      logic signed [VALUE_BITS-1:0] min;
      logic signed [VALUE_BITS-1:0] max;
      logic signed [VALUE_BITS-1:0] first;
      logic signed [VALUE_BITS-1:0] last;
      logic [COUNT_BITS-1:0]        count;
      logic signed [VALUE_BITS-1:0] mean;
      logic                         final_flag;
   } group_report_type;

   localparam group_report_type NO_REPORT = '0;

   // One directed row: a request repeated reps times, with an optional
   // hand-written report for the stream close it causes
   typedef struct {
      logic [LABEL_BITS-1:0]        label;
      logic signed [VALUE_BITS-1:0] value;
      logic                         eos;
      int                           reps;
      logic                         typed;
      group_report_type             report;
   } stim_row_type;

   logic                         clock;
   logic                         reset             = 1'b1;
   logic                         req_push          = 1'b0;
   logic                         req_full;
   logic [LABEL_BITS-1:0]        req_group_label   = '0;
   logic signed [VALUE_BITS-1:0] req_sample_value  = '0;
   logic                         req_end_of_stream = 1'b0;
   logic                         rsp_empty;
   logic                         rsp_pop           = 1'b0;
   logic signed [SUM_BITS-1:0]   rsp_group_sum;
   logic signed [VALUE_BITS-1:0] rsp_group_min;
   logic signed [VALUE_BITS-1:0] rsp_group_max;
   logic signed [VALUE_BITS-1:0] rsp_group_first;
   logic signed [VALUE_BITS-1:0] rsp_group_last;
   logic [COUNT_BITS-1:0]        rsp_group_count;
   logic signed [VALUE_BITS-1:0] rsp_group_mean;
   logic                         rsp_final_result;

   // Side band that travels with the offered request
   logic                         offer_typed  = 1'b0;
   group_report_type             offer_report = NO_REPORT;

   // Model of the open group
   logic                         grp_open;
   logic [LABEL_BITS-1:0]        grp_label;
   logic signed [SUM_BITS-1:0]   grp_sum;
   logic signed [VALUE_BITS-1:0] grp_min;
   logic signed [VALUE_BITS-1:0] grp_max;
   logic signed [VALUE_BITS-1:0] grp_first;
   logic signed [VALUE_BITS-1:0] grp_last;
   logic [COUNT_BITS-1:0]        grp_count;
   group_report_type             pending_groups[$];

   stim_row_type                 directed_rows[NUM_ROWS];
   int                           send_idle_pct   = 0;
   int                           recv_stall_pct  = 0;
   logic                         hold_pending    = 1'b0;
   int                           cycles_run      = 0;
   int                           requests_taken  = 0;
   int                           results_seen    = 0;
   int                           closes_seen     = 0;
   int                           full_stalls     = 0;
   int                           fault_count     = 0;

   segmented_group_aggregator uut (.*);

   // Free-running clock, 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Drop the open group and return to the idle state
   function automatic void clear_run();
      grp_open  = 1'b0;
      grp_label = '0;
      grp_sum   = '0;
      grp_min   = VALUE_MAX;
      grp_max   = VALUE_MIN;
      grp_first = '0;
      grp_last  = '0;
      grp_count = '0;
   endfunction

   // Aggregates of the open group, mean truncated toward zero and clamped
   function automatic group_report_type close_group(input logic final_flag);
      group_report_type r;
      longint           quotient;
      quotient = longint'(grp_sum) / longint'(grp_count);
      if (quotient > longint'(VALUE_MAX)) begin
         quotient = longint'(VALUE_MAX);
      end else if (quotient < longint'(VALUE_MIN)) begin
         quotient = longint'(VALUE_MIN);
      end
      r = '{sum: grp_sum, min: grp_min, max: grp_max, first: grp_first,
            last: grp_last, count: grp_count, mean: VALUE_BITS'(quotient),
            final_flag: final_flag};
      return r;
   endfunction

   // Fold one accepted request into the open group, queue closed groups
   function automatic void fold_sample(input logic [LABEL_BITS-1:0] label,
                                       input logic signed [VALUE_BITS-1:0] value,
                                       input logic eos,
                                       input logic typed,
                                       input group_report_type report);
      longint acc;
      if (grp_open && label != grp_label) begin
         pending_groups.push_back(close_group(1'b0));
         clear_run();
      end
      if (!grp_open) begin
         grp_open  = 1'b1;
         grp_label = label;
         grp_first = value;
      end
      // saturate the sum at its own width
      acc = longint'(grp_sum) + longint'(value);
      if (acc > longint'(SUM_MAX)) begin
         grp_sum = SUM_MAX;
      end else if (acc < longint'(SUM_MIN)) begin
         grp_sum = SUM_MIN;
      end else begin
         grp_sum = acc[SUM_BITS-1:0];
      end
      if (value < grp_min) grp_min = value;
      if (value > grp_max) grp_max = value;
      grp_last = value;
      if (grp_count != COUNT_MAX) grp_count = grp_count + 1'b1;
      if (eos) begin
         pending_groups.push_back(typed ? report : close_group(1'b1));
         clear_run();
      end
   endfunction

   function automatic group_report_type lone_sample(input logic signed [VALUE_BITS-1:0] v);
      group_report_type r;
      r = '{sum: SUM_BITS'(v), min: v, max: v, first: v, last: v,
            count: COUNT_BITS'(1), mean: v, final_flag: 1'b1};
      return r;
   endfunction

   function automatic string show(input group_report_type r);
      return $sformatf("sum=%0d min=%0d max=%0d first=%0d last=%0d count=%0d mean=%0d final=%0b",
                       r.sum, r.min, r.max, r.first, r.last, r.count, r.mean, r.final_flag);
   endfunction

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("cycle %0d: %s", cycles_run, msg);
   endfunction

   // Compare one popped result with the oldest pending group
   function automatic void check_result();
      group_report_type got;
      group_report_type want;
      string            diff;
      got = '{sum: rsp_group_sum, min: rsp_group_min, max: rsp_group_max,
              first: rsp_group_first, last: rsp_group_last, count: rsp_group_count,
              mean: rsp_group_mean, final_flag: rsp_final_result};
      results_seen++;
      if (pending_groups.size() == 0) begin
         log_fault($sformatf("unexpected group result: %s", show(got)));
      end else begin
         want = pending_groups.pop_front();
         if (want.final_flag) closes_seen++;
         diff = "";
         if (got.sum !== want.sum) diff = {diff, " sum"};
         if (got.min !== want.min) diff = {diff, " min"};
         if (got.max !== want.max) diff = {diff, " max"};
         if (got.first !== want.first) diff = {diff, " first"};
         if (got.last !== want.last) diff = {diff, " last"};
         if (got.count !== want.count) diff = {diff, " count"};
         if (got.mean !== want.mean) diff = {diff, " mean"};
         if (got.final_flag !== want.final_flag) diff = {diff, " final"};
         if (diff != "") begin
            log_fault($sformatf("result %0d wrong in%s\n   expected %s\n   actual   %s",
                                results_seen, diff, show(want), show(got)));
         end
      end
   endfunction

   // Observe both handshakes at the edge where they complete
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            requests_taken++;
            fold_sample(req_group_label, req_sample_value, req_end_of_stream,
                        offer_typed, offer_report);
         end
         if (req_push && req_full) full_stalls++;
         if (rsp_pop && !rsp_empty) check_result();
      end
   end

   // Offer one request, idling first at random, and hold it until taken
   task automatic send_request(input logic [LABEL_BITS-1:0] label,
                               input logic signed [VALUE_BITS-1:0] value,
                               input logic eos,
                               input logic typed,
                               input group_report_type report);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_group_label   <= label;
      req_sample_value  <= value;
      req_end_of_stream <= eos;
      offer_typed       <= typed;
      offer_report      <= report;
      do @(posedge clock); while (req_full);
   endtask

   function automatic logic signed [VALUE_BITS-1:0] random_sample();
      case ($urandom_range(7))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2, 3:    return VALUE_BITS'($signed($urandom_range(2000)) - 1000);
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   // Mostly runs of one label with random samples; the rest lone requests
   // with random labels and stray stream ends
   task automatic send_random_requests(input int quota);
      int                    sent;
      int                    run_len;
      logic [LABEL_BITS-1:0] label;
      logic                  closes;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(99) < 80) begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
            label   = $urandom_range(1) ? LABEL_BITS'($urandom) : LABEL_BITS'($urandom_range(3));
            closes  = ($urandom_range(5) == 0);
            for (int i = 0; i < run_len; i++) begin
               send_request(label, random_sample(), closes && (i == run_len - 1),
                            1'b0, NO_REPORT);
            end
            sent += run_len;
         end else begin
            send_request(LABEL_BITS'($urandom), random_sample(), $urandom_range(2) == 0,
                         1'b0, NO_REPORT);
            sent++;
         end
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_pop <= 1'b0;
            for (int i = 1; i < HOLD_CYCLES; i++) @(posedge clock);
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog
   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("no progress after %0d cycles, %0d groups still pending",
               cycles_run, pending_groups.size());
      $display("segmented_group_aggregator: mismatch");
      $finish;
   end

   // Main sequence
   initial begin
      clear_run();
      directed_rows = '{
         // label 0 right after reset, one-sample stream
         '{32'h0000_0000, 32'sd0, 1'b1, 1, 1'b1, lone_sample(32'sd0)},
         // extreme label and samples; same label again starts a fresh stream
         '{32'hFFFF_FFFF, VALUE_MAX, 1'b1, 1, 1'b1, lone_sample(VALUE_MAX)},
         '{32'hFFFF_FFFF, VALUE_MIN, 1'b1, 1, 1'b1, lone_sample(VALUE_MIN)},
         // label change closes a run; stream end on a run's first sample
         '{32'd5, 32'sd3, 1'b0, 1, 1'b0, NO_REPORT},
         '{32'd5, -32'sd7, 1'b0, 1, 1'b0, NO_REPORT},
         '{32'd5, 32'sd2, 1'b0, 1, 1'b0, NO_REPORT},
         '{32'd6, -32'sd5, 1'b0, 1, 1'b0, NO_REPORT},
         '{32'd7, 32'sd1, 1'b1, 1, 1'b0, NO_REPORT},
         '{32'hA5A5_A5A5, -32'sd1, 1'b0, 1, 1'b0, NO_REPORT},
         '{32'h5A5A_5A5A, 32'sd1, 1'b0, 1, 1'b0, NO_REPORT},
         '{32'h5A5A_5A5A, 32'sh1234_5678, 1'b0, 1, 1'b0, NO_REPORT},
         // negative mean truncates toward zero
         '{32'd3, -32'sd3, 1'b0, 1, 1'b0, NO_REPORT},
         '{32'd3, -32'sd4, 1'b1, 1, 1'b1,
           '{sum: SUM_BITS'(-7), min: -32'sd4, max: -32'sd3, first: -32'sd3,
             last: -32'sd4, count: COUNT_BITS'(2), mean: -32'sd3, final_flag: 1'b1}}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table with no idling
      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            send_request(directed_rows[r].label, directed_rows[r].value,
                         directed_rows[r].eos && (k == directed_rows[r].reps - 1),
                         directed_rows[r].typed && (k == directed_rows[r].reps - 1),
                         directed_rows[r].report);
         end
      end

      // Random runs under each idle mix; the first starts with a long hold-off
      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct  = SEND_IDLE[p];
         recv_stall_pct = RECV_STALL[p];
         if (p == 0) hold_pending = 1'b1;
         send_random_requests(RANDOM_PER_PHASE);
      end

      // Close the last open run so it gets checked too
      send_request(LABEL_BITS'($urandom), random_sample(), 1'b1, 1'b0, NO_REPORT);
      req_push <= 1'b0;

      // Drain, then watch a while for stray results
      while (pending_groups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests in %0d cycles: directed edge labels and samples, then",
               requests_taken, cycles_run);
      $display("random label runs under five idle mixes and a long hold-off;");
      $display("%0d groups checked, %0d stream ends, %0d full stalls.",
               results_seen, closes_seen, full_stalls);
      if (fault_count == 0) begin
         $display("segmented_group_aggregator: match");
      end else begin
         $display("segmented_group_aggregator: mismatch");
      end
      $finish;
   end

endmodule
